/* design/dsec_pkg.sv */
`default_nettype none
package dsec_pkg;

  // stream widths: tuser carries selectors and flags, tdata the payload
  localparam int IN_USER_W  = 4;
  localparam int IN_DATA_W  = 184;
  localparam int OUT_USER_W = 6;
  localparam int OUT_DATA_W = 192;

  localparam logic [2:0] RK_IGNORED  = 3'd0;
  localparam logic [2:0] RK_QUEUED   = 3'd1;
  localparam logic [2:0] RK_MATCHED  = 3'd2;
  localparam logic [2:0] RK_MISMATCH = 3'd3;
  localparam logic [2:0] RK_DROPPED  = 3'd4;
  localparam logic [2:0] RK_EXPIRED  = 3'd5;

  localparam logic [1:0] KIND_CONNECT = 2'd1;
  localparam logic [1:0] KIND_OTHER   = 2'd3;

  localparam logic [1:0] REG_WINDOW   = 2'd0;
  localparam logic [1:0] REG_EXPIRY   = 2'd1;
  localparam logic [1:0] REG_COOLDOWN = 2'd2;
  localparam logic [1:0] REG_SWEEP    = 2'd3;

  // one request as held in the front queue
  typedef struct packed {
    logic        action;
    logic        source;
    logic [1:0]  event_kind;
    logic [31:0] process_id;
    logic [63:0] event_stamp;
    logic [63:0] content_digest;
    logic [15:0] dest_port;
    logic [7:0]  addr_family;
  } req_t;

endpackage
`default_nettype wire

/* design/dsec_front.sv */
`default_nettype none
// Front end: accepts requests, unpacks them and queues them for the engine.
module dsec_front #(
  parameter int QDEPTH = 2
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // action, source, event_kind
  input  wire logic [dsec_pkg::IN_USER_W-1:0] in_tuser,
  // process_id, event_stamp, content_digest, dest_port, addr_family
  input  wire logic [dsec_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                                 q_valid,
  input  wire logic                            q_pop,
  output dsec_pkg::req_t                       q_req
);
  import dsec_pkg::*;

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  req_t             mem_r [QDEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;
  req_t             req;
  logic             push;

  // unpack, lowest field first
  always_comb begin
    req.action         = in_tuser[0];
    req.source         = in_tuser[1];
    req.event_kind     = in_tuser[3:2];
    req.process_id     = in_tdata[31:0];
    req.event_stamp    = in_tdata[95:32];
    req.content_digest = in_tdata[159:96];
    req.dest_port      = in_tdata[175:160];
    req.addr_family    = in_tdata[183:176];
  end

  assign in_tready = (cnt_r != (AW+1)'(QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_req     = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(QDEPTH-1)) ? '0 : wp_r + 1'b1;
      if (q_pop) rp_r <= (rp_r == AW'(QDEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(q_pop);
    end
  end
endmodule
`default_nettype wire

/* design/dsec_engine.sv */
`default_nettype none
// Back end: scans pending and cooldown tables one entry per cycle.
module dsec_engine #(
  parameter int PENDING_DEPTH  = 16,
  parameter int COOLDOWN_DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  output logic                              q_pop,
  input  dsec_pkg::req_t                    q_req,
  input  wire logic                         cfg_valid,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [15:0]                  cfg_data,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // result_kind, alert_raised, missing_source
  output logic [dsec_pkg::OUT_USER_W-1:0]   out_tuser,
  // alert_pid, alert_stamp, matched_total, diverged_total, events_total
  output logic [dsec_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tlast
);
  import dsec_pkg::*;

  localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CW = (COOLDOWN_DEPTH > 1) ? $clog2(COOLDOWN_DEPTH) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;  // match or expiry scan of pending table
  localparam logic [3:0] S_DEC   = 4'd2;  // act on scan winner
  localparam logic [3:0] S_CFIND = 4'd3;  // cooldown lookup
  localparam logic [3:0] S_CMARK = 4'd4;  // cooldown write
  localparam logic [3:0] S_EMIT  = 4'd5;
  localparam logic [3:0] S_FREE  = 4'd6;  // free slot search
  localparam logic [3:0] S_RDE   = 4'd7;  // read expired entry

  // pending table
  logic                 ev_r [PENDING_DEPTH];
  logic                 es_r [PENDING_DEPTH];
  logic [1:0]           ek_r [PENDING_DEPTH];
  logic [31:0]          ep_r [PENDING_DEPTH];
  logic [63:0]          ed_r [PENDING_DEPTH];
  logic [15:0]          eo_r [PENDING_DEPTH];
  logic [7:0]           ef_r [PENDING_DEPTH];
  logic [63:0]          et_r [PENDING_DEPTH];
  logic [31:0]          ea_r [PENDING_DEPTH];
  logic [31:0]          eq_r [PENDING_DEPTH];
  logic                 xf_r [PENDING_DEPTH];  // expiry flags
  // cooldown store
  logic                 cv_r [COOLDOWN_DEPTH];
  logic [31:0]          cp_r [COOLDOWN_DEPTH];
  logic [31:0]          ct_r [COOLDOWN_DEPTH];

  logic [15:0] win_r, exp_r, cool_r;
  logic [9:0]  per_r, swc_r;
  logic [31:0] now_r, seq_r, mcnt_r, dcnt_r, ecnt_r;

  logic [3:0]    st_r;
  req_t          rq_r;
  logic [PW:0]   pi_r;
  logic [CW:0]   ci_r;
  logic          hit_r;
  logic [PW-1:0] best_r;
  logic [31:0]   bage_r;
  logic          sweep_r;     // servicing a tick
  logic          ffound_r;
  logic          cfound_r, ccool_r, cfree_r;
  logic [CW-1:0] cslot_r, cfslot_r, coslot_r;
  logic [31:0]   cbest_r;
  logic [31:0]   apid_r;
  logic [2:0]    rk_r;
  logic [1:0]    miss_r;
  logic          alert_r;
  logic [63:0]   astamp_r;

  // result register, holds a result while the engine moves on
  logic                  out_valid_r, out_last_r;
  logic [OUT_USER_W-1:0] out_user_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [PW-1:0] pi;
  logic [CW-1:0] ci;
  logic [31:0]   age, el;
  logic          cand;
  logic          same;
  logic          more;

  assign pi = pi_r[PW-1:0];
  assign ci = ci_r[CW-1:0];
  assign age = seq_r - eq_r[pi];
  assign el  = now_r - ct_r[ci];
  assign q_pop = (st_r == S_IDLE) && q_valid;

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    if (sweep_r)
      cand = ev_r[pi] && xf_r[pi];
    else
      cand = ev_r[pi] && (es_r[pi] != rq_r.source) &&
             ((now_r - ea_r[pi]) <= {16'd0, win_r}) &&
             (ep_r[pi] == rq_r.process_id) && (ek_r[pi] == rq_r.event_kind);
  end

  assign same = (ed_r[best_r] == rq_r.content_digest) &&
                ((rq_r.event_kind != KIND_CONNECT) ||
                 ((eo_r[best_r] == rq_r.dest_port) && (ef_r[best_r] == rq_r.addr_family)));

  // flagged entries still waiting in the current sweep
  always_comb begin
    more = 1'b0;
    for (int i = 0; i < PENDING_DEPTH; i++)
      if (xf_r[i] && ev_r[i]) more = 1'b1;
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= 16'd50;
      exp_r  <= 16'd500;
      cool_r <= 16'd5000;
      per_r  <= 10'd100;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WINDOW:   win_r  <= cfg_data;
        REG_EXPIRY:   exp_r  <= cfg_data;
        REG_COOLDOWN: cool_r <= cfg_data;
        REG_SWEEP:    per_r  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // payload of pending table
  always_ff @(posedge clk) begin
    if (st_r == S_FREE && !ev_r[pi] && !ffound_r) begin
      es_r[pi] <= rq_r.source;
      ek_r[pi] <= rq_r.event_kind;
      ep_r[pi] <= rq_r.process_id;
      ed_r[pi] <= rq_r.content_digest;
      eo_r[pi] <= rq_r.dest_port;
      ef_r[pi] <= rq_r.addr_family;
      et_r[pi] <= rq_r.event_stamp;
      ea_r[pi] <= now_r;
      eq_r[pi] <= seq_r;
    end
    // mark the pid only when the alert is actually raised
    if (st_r == S_CMARK && cfound_r && ccool_r) begin
      cp_r[cslot_r] <= apid_r;
      ct_r[cslot_r] <= now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      for (int i = 0; i < PENDING_DEPTH; i++) begin
        ev_r[i] <= 1'b0;
        xf_r[i] <= 1'b0;
      end
      for (int i = 0; i < COOLDOWN_DEPTH; i++) cv_r[i] <= 1'b0;
      now_r <= '0; swc_r <= '0; seq_r <= '0;
      mcnt_r <= '0; dcnt_r <= '0; ecnt_r <= '0;
      out_valid_r <= 1'b0; out_last_r <= 1'b0;
      out_user_r <= '0; out_data_r <= '0;
      sweep_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (q_pop) begin
          rq_r  <= q_req;
          pi_r  <= '0;
          hit_r <= 1'b0;
          apid_r <= q_req.process_id;
          astamp_r <= q_req.event_stamp;
          alert_r <= 1'b0;
          miss_r <= 2'd0;
          if (q_req.action) begin
            now_r <= now_r + 1'b1;
            if ((swc_r + 1'b1) < per_r) begin
              swc_r <= swc_r + 1'b1;
            end else begin
              swc_r <= '0;
              sweep_r <= 1'b1;
              for (int i = 0; i < PENDING_DEPTH; i++)
                xf_r[i] <= ev_r[i] && ((now_r + 1'b1 - ea_r[i]) > {16'd0, exp_r});
              st_r <= S_SCAN;
            end
          end else begin
            ecnt_r <= ecnt_r + 1'b1;
            sweep_r <= 1'b0;
            if (q_req.event_kind == KIND_OTHER) begin
              rk_r <= RK_IGNORED;
              st_r <= S_EMIT;
            end else begin
              st_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cand && (!hit_r || age > bage_r)) begin
            hit_r <= 1'b1;
            best_r <= pi;
            bage_r <= age;
          end
          if (pi_r == (PW+1)'(PENDING_DEPTH-1)) st_r <= S_DEC;
          else pi_r <= pi_r + 1'b1;
        end
        S_DEC: begin
          pi_r <= '0;
          ffound_r <= 1'b0;
          if (sweep_r) begin
            if (!hit_r) begin
              sweep_r <= 1'b0;
              st_r <= S_IDLE;
            end else st_r <= S_RDE;
          end else if (hit_r) begin
            ev_r[best_r] <= 1'b0;
            if (same) begin
              mcnt_r <= mcnt_r + 1'b1;
              rk_r <= RK_MATCHED;
              st_r <= S_EMIT;
            end else begin
              dcnt_r <= dcnt_r + 1'b1;
              rk_r <= RK_MISMATCH;
              ci_r <= '0; cfound_r <= 1'b0; cfree_r <= 1'b0;
              st_r <= S_CFIND;
            end
          end else st_r <= S_FREE;
        end
        S_RDE: begin
          ev_r[best_r] <= 1'b0;
          xf_r[best_r] <= 1'b0;
          dcnt_r <= dcnt_r + 1'b1;
          rk_r <= RK_EXPIRED;
          apid_r <= ep_r[best_r];
          astamp_r <= et_r[best_r];
          miss_r <= es_r[best_r] ? 2'd2 : 2'd1;
          ci_r <= '0; cfound_r <= 1'b0; cfree_r <= 1'b0;
          st_r <= S_CFIND;
        end
        S_FREE: begin
          if (!ev_r[pi] && !ffound_r) begin
            ffound_r <= 1'b1;
            ev_r[pi] <= 1'b1;
            seq_r <= seq_r + 1'b1;
          end
          if (pi_r == (PW+1)'(PENDING_DEPTH-1)) begin
            rk_r <= (ffound_r || !ev_r[pi]) ? RK_QUEUED : RK_DROPPED;
            st_r <= S_EMIT;
          end else pi_r <= pi_r + 1'b1;
        end
        S_CFIND: begin
          if (cv_r[ci] && cp_r[ci] == apid_r && !cfound_r) begin
            cfound_r <= 1'b1;
            cslot_r <= ci;
            ccool_r <= (el >= {16'd0, cool_r});
          end
          if (!cv_r[ci] && !cfree_r) begin
            cfree_r <= 1'b1;
            cfslot_r <= ci;
          end
          if (ci_r == '0 || el > cbest_r) begin
            cbest_r <= el;
            coslot_r <= ci;
          end
          if (ci_r == (CW+1)'(COOLDOWN_DEPTH-1)) st_r <= S_CMARK;
          else ci_r <= ci_r + 1'b1;
        end
        S_CMARK: begin
          if (cfound_r && !ccool_r) begin
            alert_r <= 1'b0;
            st_r <= S_EMIT;
          end else if (!cfound_r) begin
            // unknown pid: take a free slot or the stalest one, mark next cycle
            cslot_r <= cfree_r ? cfslot_r : coslot_r;
            cfound_r <= 1'b1;
            ccool_r <= 1'b1;
          end else begin
            alert_r <= 1'b1;
            cv_r[cslot_r] <= 1'b1;
            st_r <= S_EMIT;
          end
        end
        S_EMIT: if (!out_valid_r) begin
          out_valid_r <= 1'b1;
          out_user_r <= {miss_r, alert_r, rk_r};
          out_data_r <= {ecnt_r, dcnt_r, mcnt_r, astamp_r, apid_r};
          pi_r <= '0;
          hit_r <= 1'b0;
          // last is known only if no further flagged entry remains
          if (sweep_r && more) begin
            out_last_r <= 1'b0;
            st_r <= S_SCAN;
          end else begin
            out_last_r <= 1'b1;
            sweep_r <= 1'b0;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* design/dual_source_event_correlator_core.sv */
`default_nettype none
// Channel  Dir  Handshake              Payload
// in_      in   in_tvalid/in_tready    in_tuser[3:0], in_tdata[183:0]: event or tick
// out_     out  out_tvalid/out_tready  out_tuser[5:0], out_tdata[191:0], out_tlast: result
// cfg_     in   cfg_valid/cfg_ready    cfg_index[1:0], cfg_data[15:0]: register write
// One request at a time, pop to result: an ignored event goes straight to its result,
// a match needs a pending-table scan, a queued or dropped event a second scan for a
// free slot, a content mismatch a cooldown scan after the first (plus a mark step
// for an unknown pid); the tables are scanned one entry a cycle. Tick: no result
// unless a sweep is due, which scans the pending table and checks each expired entry.
// Reset is synchronous; tables start empty. A two-deep queue decouples input, and a
// result register lets the engine go on until the next result meets a stalled output.
module dual_source_event_correlator_core #(
  parameter int PENDING_DEPTH  = 16,
  parameter int COOLDOWN_DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // action, source, event_kind
  input  wire logic [dsec_pkg::IN_USER_W-1:0]  in_tuser,
  // process_id, event_stamp, content_digest, dest_port, addr_family
  input  wire logic [dsec_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // result_kind, alert_raised, missing_source
  output logic [dsec_pkg::OUT_USER_W-1:0]       out_tuser,
  // alert_pid, alert_stamp, matched_total, diverged_total, events_total
  output logic [dsec_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                  out_tlast,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [1:0]                       cfg_index,
  input  wire logic [15:0]                      cfg_data
);
  import dsec_pkg::*;

  logic q_valid, q_pop;
  req_t q_req;

  assign cfg_ready = 1'b1;

  dsec_front #(.QDEPTH(2)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tuser, .in_tdata,
    .q_valid, .q_pop, .q_req
  );

  dsec_engine #(.PENDING_DEPTH(PENDING_DEPTH), .COOLDOWN_DEPTH(COOLDOWN_DEPTH)) u_eng (
    .clk, .rst_n, .q_valid, .q_pop, .q_req,
    .cfg_valid, .cfg_index, .cfg_data,
    .out_tvalid, .out_tready, .out_tuser, .out_tdata, .out_tlast
  );
endmodule
`default_nettype wire
